### sv/sv39ptb_pkg.sv
// ----------------------------------------------------------------------------
// sv39ptb_pkg
// Types and constants shared by the Sv39 page table builder.
// ----------------------------------------------------------------------------
package sv39ptb_pkg;

    localparam int POOL_PAGES_DEF = 16;

    localparam int VPN_W   = 27;
    localparam int PPN_W   = 44;
    localparam int CNT_W   = 21;
    localparam int PERM_W  = 8;
    localparam int RPAGE_W = 4;
    localparam int IDX_W   = 9;
    localparam int WORD_W  = 64;
    localparam int USED_W  = 5;

    // entry layout and index positions within the virtual page number
    localparam int PTE_PPN_LSB = 10;
    localparam int VPN2_LSB    = 18;
    localparam int VPN1_LSB    = 9;
    localparam int VPN0_LSB    = 0;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [0:0] {
        OP_MAP  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [VPN_W-1:0]   va_page;
        logic [PPN_W-1:0]   pa_page;
        logic [CNT_W-1:0]   page_count;
        logic [PERM_W-1:0]  perm;
        logic [RPAGE_W-1:0] read_page;
        logic [IDX_W-1:0]   read_index;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [WORD_W-1:0]  read_data;
        logic [CNT_W-1:0]   pages_mapped;
        logic [USED_W-1:0]  tables_used;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_L2_RD,
        S_L2_CHK,
        S_L1_RD,
        S_L1_CHK,
        S_LEAF,
        S_RESP
    } t_state;

endpackage

### sv/sv39ptb_table_mem.sv
// ----------------------------------------------------------------------------
// sv39ptb_table_mem
// Table word store for the pool: one write and one registered read per
// cycle, with a zeroing sweep over every word after reset.
// ----------------------------------------------------------------------------
module sv39ptb_table_mem
    import sv39ptb_pkg::*;
#(
    parameter int POOL_PAGES = POOL_PAGES_DEF,
    localparam int ADDR_W = $clog2(POOL_PAGES) + IDX_W,
    localparam int DEPTH  = POOL_PAGES * (1 << IDX_W)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata,
    output logic              o_clr_busy
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

### sv/sv39_page_table_builder.sv
// ----------------------------------------------------------------------------
// sv39_page_table_builder
// Builds a three-level Sv39 page table in a local pool of table pages.
// ----------------------------------------------------------------------------
// After reset the table store is zeroed one word a cycle, and no request is
// taken until that sweep ends. A map request then walks each page through
// S_L2_RD, S_L2_CHK, S_L1_RD, S_L1_CHK and S_LEAF: the level-2 and level-1
// entries each take a read state and a check/allocate state on the single
// table port, and the leaf write takes one more. A zero count goes straight
// to S_RESP. A read request passes S_RD_ISSUE and S_RD_DATA. S_RESP loads
// the response register once it is free; the next request is taken while a response still waits.
module sv39_page_table_builder
    import sv39ptb_pkg::*;
#(
    parameter int POOL_PAGES = POOL_PAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [PPN_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req             i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp             o_out_data
);

    localparam int PG_W   = $clog2(POOL_PAGES);
    localparam int NF_W   = $clog2(POOL_PAGES + 1);
    localparam int ADDR_W = PG_W + IDX_W;

    t_state            r_state, n_state;
    logic [PPN_W-1:0]  r_base;
    logic [NF_W-1:0]   r_nf, n_nf;
    logic [VPN_W-1:0]  r_va, n_va;
    logic [PPN_W-1:0]  r_pa, n_pa;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_done, n_done;
    logic [PERM_W-1:0] r_perm, n_perm;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [PG_W-1:0]   r_page, n_page;
    logic              r_page_ok, n_page_ok;
    logic              r_status, n_status;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    logic              w_clr_busy;
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_idx;
    logic [WORD_W-1:0] w_mem_wdata;
    logic [WORD_W-1:0] w_rdata;
    logic [WORD_W-1:0] w_entry;
    logic [PPN_W-1:0]  w_rel;
    logic              w_rel_ok;
    logic              w_full;
    logic              w_accept;
    logic              w_load_out;

    sv39ptb_table_mem #(
        .POOL_PAGES (POOL_PAGES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_mem_we),
        .i_addr     ({r_page, w_mem_idx}),
        .i_wdata    (w_mem_wdata),
        .o_rdata    (w_rdata),
        .o_clr_busy (w_clr_busy)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !w_clr_busy;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an entry of a page outside the pool reads as zero
    assign w_entry  = r_page_ok ? w_rdata : '0;
    assign w_rel    = w_entry[PTE_PPN_LSB +: PPN_W] - r_base;
    assign w_rel_ok = w_rel < PPN_W'(POOL_PAGES);
    assign w_full   = r_nf >= NF_W'(POOL_PAGES);

    always_comb begin
        case (r_state)
            S_RD_ISSUE:        w_mem_idx = r_idx;
            S_L2_RD, S_L2_CHK: w_mem_idx = r_va[VPN2_LSB +: IDX_W];
            S_L1_RD, S_L1_CHK: w_mem_idx = r_va[VPN1_LSB +: IDX_W];
            default:           w_mem_idx = r_va[VPN0_LSB +: IDX_W];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_nf        = r_nf;
        n_va        = r_va;
        n_pa        = r_pa;
        n_count     = r_count;
        n_done      = r_done;
        n_perm      = r_perm;
        n_idx       = r_idx;
        n_page      = r_page;
        n_page_ok   = r_page_ok;
        n_status    = r_status;
        n_word      = r_word;
        w_mem_we    = 1'b0;
        w_mem_wdata = '0;
        w_load_out  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_done   = '0;
                    n_word   = '0;
                    n_status = ST_DONE;
                    if (i_in_data.op == OP_READ) begin
                        n_page    = PG_W'(i_in_data.read_page);
                        n_page_ok = 32'(i_in_data.read_page) < POOL_PAGES;
                        n_idx     = i_in_data.read_index;
                        n_state   = S_RD_ISSUE;
                    end else begin
                        n_va      = i_in_data.va_page;
                        n_pa      = i_in_data.pa_page;
                        n_count   = i_in_data.page_count;
                        n_perm    = i_in_data.perm;
                        n_page    = '0;
                        n_page_ok = 1'b1;
                        n_state   = (i_in_data.page_count == '0) ? S_RESP : S_L2_RD;
                    end
                end
            end
            S_RD_ISSUE: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_word  = w_entry;
                n_state = S_RESP;
            end
            S_L2_RD: begin
                n_state = S_L2_CHK;
            end
            S_L1_RD: begin
                n_state = S_L1_CHK;
            end
            S_L2_CHK, S_L1_CHK: begin
                if (w_entry[0]) begin
                    n_page    = w_rel[PG_W-1:0];
                    n_page_ok = w_rel_ok;
                    n_state   = (r_state == S_L2_CHK) ? S_L1_RD : S_LEAF;
                end else if (w_full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    // allocate the next free pool page behind this entry
                    w_mem_we    = r_page_ok;
                    w_mem_wdata = {{(WORD_W - PPN_W - PTE_PPN_LSB){1'b0}},
                                   r_base + PPN_W'(r_nf),
                                   {(PTE_PPN_LSB - 1){1'b0}}, 1'b1};
                    n_page      = r_nf[PG_W-1:0];
                    n_page_ok   = 1'b1;
                    n_nf        = r_nf + 1'b1;
                    n_state     = (r_state == S_L2_CHK) ? S_L1_RD : S_LEAF;
                end
            end
            S_LEAF: begin
                w_mem_we    = r_page_ok;
                w_mem_wdata = {{(WORD_W - PPN_W - PTE_PPN_LSB){1'b0}}, r_pa,
                               {(PTE_PPN_LSB - PERM_W){1'b0}}, r_perm};
                n_done      = r_done + 1'b1;
                n_va        = r_va + 1'b1;
                n_pa        = r_pa + 1'b1;
                n_page      = '0;
                n_page_ok   = 1'b1;
                n_state     = (n_done == r_count) ? S_RESP : S_L2_RD;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = w_load_out || (r_out_valid && !i_out_ready);
        n_out       = r_out;
        if (w_load_out) begin
            n_out.status       = r_status;
            n_out.read_data    = r_word;
            n_out.pages_mapped = r_done;
            n_out.tables_used  = USED_W'(r_nf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_nf        <= NF_W'(1);
            r_count     <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nf        <= n_nf;
            r_count     <= n_count;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_va      <= n_va;
        r_pa      <= n_pa;
        r_perm    <= n_perm;
        r_idx     <= n_idx;
        r_page    <= n_page;
        r_page_ok <= n_page_ok;
        r_status  <= n_status;
        r_word    <= n_word;
        r_out     <= n_out;
    end

    // pool allocation never runs past the last page
    a_nf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= NF_W'(POOL_PAGES) && r_nf != '0)
        else $error("free page counter out of range");

    // the walker never writes the store while it is being cleared
    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !w_clr_busy)
        else $error("table write during clearing sweep");

    // a request never maps more pages than asked for
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_count)
        else $error("mapped page count exceeds request");

    // an allocation bumps the free counter by exactly one
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_L2_CHK || r_state == S_L1_CHK) && !w_entry[0] && !w_full)
        |=> r_nf == $past(r_nf) + 1'b1)
        else $error("pool allocation miscounted");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Sv39 page table builder. A directed run walks and
// fills the table pool, covering wrap-around, zero counts and pool exhaustion.
// Random map and read traffic then follows under several pool base settings,
// and every response is checked against a table model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sv39ptb_pkg::*;

    localparam int POOL       = POOL_PAGES_DEF;
    localparam int WORDS      = POOL * 512;
    localparam int IDLE_LIMIT = 100000;
    localparam int HOLD_AT    = 60;
    localparam int HOLD_LEN   = 300;
    localparam int N_REGIONS  = 9;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [PPN_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    t_req             in_req      = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    t_rsp             out_rsp;

    sv39_page_table_builder dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_req),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_rsp)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // table model
    logic [WORD_W-1:0]  pt_words [WORDS];
    int unsigned        next_free;
    logic [PPN_W-1:0]   base_ppn;

    // recent table writes, used to aim reads at live entries
    logic [RPAGE_W-1:0] wlog_pg  [8];
    logic [IDX_W-1:0]   wlog_idx [8];
    int                 wlog_n = 0;

    logic [VPN_W-1:0]   leaf_regions [N_REGIONS];

    t_req req_q[$];
    t_rsp pending_rsp[$];
    t_rsp exp_rsp;

    int errors       = 0;
    int n_maps       = 0;
    int n_reads      = 0;
    int n_full       = 0;
    int pages_total  = 0;
    int results_seen = 0;
    int tx_wait      = 0;
    int rx_wait      = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;

    function automatic int pool_index(logic [PPN_W-1:0] ppn);
        logic [PPN_W-1:0] rel;
        rel = ppn - base_ppn;
        return (rel < POOL) ? int'(rel) : -1;
    endfunction

    function automatic logic [WORD_W-1:0] pt_load(int pg, logic [IDX_W-1:0] idx);
        if (pg < 0)
            return '0;
        return pt_words[pg * 512 + int'(idx)];
    endfunction

    function automatic void pt_store(int pg, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] w);
        if (pg < 0)
            return;
        pt_words[pg * 512 + int'(idx)] = w;
        wlog_pg[wlog_n % 8]  = pg[RPAGE_W-1:0];
        wlog_idx[wlog_n % 8] = idx;
        wlog_n++;
    endfunction

    // follow one table entry, allocating a fresh pool page where it is not valid
    function automatic int walk_level(int pg, logic [IDX_W-1:0] idx, output bit full);
        logic [WORD_W-1:0] w;
        int                fresh;
        full = 1'b0;
        w = pt_load(pg, idx);
        if (w[0])
            return pool_index(w[PTE_PPN_LSB +: PPN_W]);
        if (next_free >= POOL) begin
            full = 1'b1;
            return -1;
        end
        fresh = next_free;
        next_free++;
        w = '0;
        w[PTE_PPN_LSB +: PPN_W] = base_ppn + PPN_W'(fresh);
        w[0] = 1'b1;
        pt_store(pg, idx, w);
        return fresh;
    endfunction

    function automatic t_rsp build_response(t_req r);
        t_rsp              rsp;
        logic [VPN_W-1:0]  va;
        logic [PPN_W-1:0]  pa;
        logic [WORD_W-1:0] leaf;
        int                t1;
        int                t0;
        bit                full;
        int unsigned       done;
        rsp  = '0;
        full = 1'b0;
        done = 0;
        t0   = -1;
        if (r.op == OP_READ) begin
            if (r.read_page < POOL)
                rsp.read_data = pt_load(int'(r.read_page), r.read_index);
        end else begin
            va = r.va_page;
            pa = r.pa_page;
            while (done < r.page_count && !full) begin
                t1 = walk_level(0, va[VPN2_LSB +: IDX_W], full);
                if (!full)
                    t0 = walk_level(t1, va[VPN1_LSB +: IDX_W], full);
                if (!full) begin
                    leaf = '0;
                    leaf[PTE_PPN_LSB +: PPN_W] = pa;
                    leaf[PERM_W-1:0] = r.perm;
                    pt_store(t0, va[VPN0_LSB +: IDX_W], leaf);
                    done++;
                    va++;
                    pa++;
                end
            end
            rsp.status = full ? ST_FULL : ST_DONE;
        end
        rsp.pages_mapped = CNT_W'(done);
        rsp.tables_used  = USED_W'(next_free);
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // request side: driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end else if (!in_valid || in_ready) begin
            if (tx_wait > 0) begin
                tx_wait--;
                in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                in_req   <= req_q.pop_front();
                in_valid <= 1'b1;
                tx_wait = tx_steady ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // request side: predict on acceptance
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            pending_rsp.push_back(build_response(in_req));
            if (in_req.op == OP_READ)
                n_reads++;
            else
                n_maps++;
        end
    end

    // response side: stall and check
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_wait = 0;
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_rsp.size() == 0) begin
                    $display("%0t: response with no request outstanding, actual 0x%0h",
                             $time, out_rsp);
                    errors++;
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    check_field("status", exp_rsp.status, out_rsp.status);
                    check_field("read_data", exp_rsp.read_data, out_rsp.read_data);
                    check_field("pages_mapped", exp_rsp.pages_mapped, out_rsp.pages_mapped);
                    check_field("tables_used", exp_rsp.tables_used, out_rsp.tables_used);
                    if (exp_rsp.status == ST_FULL)
                        n_full++;
                    pages_total += int'(exp_rsp.pages_mapped);
                end
                rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0)
                    rx_steady = !rx_steady;
                // one long hold-off so the block backs up and stalls its input
                if (results_seen == HOLD_AT)
                    rx_wait = HOLD_LEN;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            out_ready <= (rx_wait == 0);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: %0d cycles with nothing moving", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic push_req(t_req r);
        while (req_q.size() >= 2)
            @(posedge clk);
        req_q.push_back(r);
    endtask

    task automatic send_map(logic [VPN_W-1:0] va, logic [PPN_W-1:0] pa,
                            logic [CNT_W-1:0] cnt, logic [PERM_W-1:0] perm);
        t_req r;
        r            = '0;
        r.op         = OP_MAP;
        r.va_page    = va;
        r.pa_page    = pa;
        r.page_count = cnt;
        r.perm       = perm;
        push_req(r);
    endtask

    task automatic send_read(logic [RPAGE_W-1:0] pg, logic [IDX_W-1:0] idx);
        t_req r;
        r            = '0;
        r.op         = OP_READ;
        r.read_page  = pg;
        r.read_index = idx;
        push_req(r);
    endtask

    // wait until every request is in and every response is back
    task automatic drain();
        do
            @(posedge clk);
        while (req_q.size() != 0 || in_valid || pending_rsp.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_pool_base(logic [PPN_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        base_ppn = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly maps into leaf tables that already exist, since the pool fills early
    task automatic send_random(bit huge_ok);
        int               sel;
        int               slot;
        logic [VPN_W-1:0] va;
        logic [CNT_W-1:0] cnt;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            if (sel < 15 || wlog_n == 0) begin
                send_read(RPAGE_W'($urandom), IDX_W'($urandom));
            end else begin
                slot = $urandom_range(0, ((wlog_n < 8) ? wlog_n : 8) - 1);
                send_read(wlog_pg[slot], wlog_idx[slot]);
            end
        end else if (sel < 88) begin
            va = leaf_regions[$urandom_range(0, N_REGIONS - 1)] + VPN_W'($urandom_range(0, 511));
            sel = $urandom_range(0, 99);
            if (huge_ok && sel < 3)
                cnt = CNT_W'($urandom);
            else if (sel < 70)
                cnt = CNT_W'($urandom_range(0, 8));
            else if (sel < 95)
                cnt = CNT_W'($urandom_range(9, 120));
            else
                cnt = CNT_W'($urandom_range(121, 600));
            send_map(va, PPN_W'({$urandom, $urandom}), cnt, PERM_W'($urandom));
        end else begin
            cnt = huge_ok ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 600));
            send_map(VPN_W'($urandom), PPN_W'({$urandom, $urandom}), cnt, PERM_W'($urandom));
        end
    endtask

    initial begin : stimulus
        int k;
        for (k = 0; k < WORDS; k++)
            pt_words[k] = '0;
        next_free = 1;
        base_ppn  = '0;
        leaf_regions = '{27'h7FFFE00, 27'h0000000, 27'h0000200, 27'h5555400, 27'h2AAAA00,
                         27'h1000000, 27'h1000200, 27'h1000400, 27'h1000600};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_pool_base('0);

        // directed: wrap, zero count, alternating bit patterns, then fill the pool
        send_read(4'd0, 9'd0);
        send_map(27'h7FFFFFF, 44'hFFFFFFFFFFF, 21'd0, 8'hFF);
        send_map(27'h7FFFFFE, 44'hFFFFFFFFFFE, 21'd4, 8'hFF);
        send_read(4'd2, 9'd511);
        send_read(4'd0, 9'd511);
        send_read(4'd4, 9'd1);
        send_map(27'h00001FE, 44'h0, 21'd4, 8'h00);
        send_map(27'h5555555, 44'hAAAAAAAAAAA, 21'd1, 8'hAA);
        send_map(27'h2AAAAAA, 44'h55555555555, 21'd1, 8'h55);
        send_read(4'd15, 9'd511);
        send_map(27'h1000000, 44'h123456789AB, 21'd2048, 8'hCF);
        // level-2 entry gets the last page, level-1 allocation then fails
        send_map(27'h3000000, 44'h0, 21'd2, 8'h01);
        send_map(27'h1000800, 44'hFFF, 21'h100000, 8'h80);
        // two leaves land before the pool runs dry
        send_map(27'h10007FE, 44'h777, 21'd4, 8'h3C);
        send_read(4'd14, 9'd511);
        send_read(4'd0, 9'd192);
        send_read(4'd10, 9'd3);
        drain();

        for (k = 0; k < 400; k++) begin
            if (k == 200)
                drain();
            send_random(1'b1);
        end
        drain();

        // base at the top of the range: every pool pointer shifts by one page
        set_pool_base(44'hFFFFFFFFFFF);
        for (k = 0; k < 180; k++)
            send_random(1'b0);
        drain();

        set_pool_base(PPN_W'({$urandom, $urandom}));
        for (k = 0; k < 180; k++)
            send_random(1'b0);
        drain();

        set_pool_base(44'd3);
        for (k = 0; k < 180; k++)
            send_random(1'b0);
        drain();

        set_pool_base('0);
        for (k = 0; k < 210; k++)
            send_random(1'b0);
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d map and %0d read requests under five pool base settings",
                 n_maps, n_reads);
        $display("%0d leaf pages mapped, %0d requests hit a full pool, %0d errors",
                 pages_total, n_full, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
